[hw/rtl/brbf_pkg.sv]
// Shared types and constants for the circular byte FIFO.
package brbf_pkg;

	// Width of the capacity, amount and count fields
	localparam int CNT_W = 13;

	// Capacity register value after reset
	localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

	// Operation codes
	localparam logic [2:0] OP_PUSH      = 3'd0;
	localparam logic [2:0] OP_POP       = 3'd1;
	localparam logic [2:0] OP_PEEK      = 3'd2;
	localparam logic [2:0] OP_SKIP      = 3'd3;
	localparam logic [2:0] OP_SET_END   = 3'd4;
	localparam logic [2:0] OP_CLEAR_END = 3'd5;
	localparam logic [2:0] OP_RESET     = 3'd6;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_EMPTY_END = 2'd3;

	// Input item
	typedef struct packed {
		logic [2:0]       operation;
		logic [7:0]       data_in;
		logic [CNT_W-1:0] amount;
	} brbf_in_t;

	// Result item
	typedef struct packed {
		logic [7:0]       data_out;
		logic [CNT_W-1:0] moved;
		logic [1:0]       status;
		logic [CNT_W-1:0] fill_level;
		logic [CNT_W-1:0] space_left;
		logic             end_flag;
	} brbf_out_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic latch_item;
		logic execute;
		logic load_result;
	} brbf_cmd_t;

endpackage

[hw/rtl/byte_ring_buffer_fifo.sv]
// Top level of the circular byte FIFO: controller, datapath and checks.
//
// Channel   Signals                         Transfer
// in        in_valid, in_ready, in_item     item when valid and ready high
// out       out_valid, out_ready, out_item  item when valid and ready high
// cfg       cfg_we, cfg_data                write when cfg_we high
//
// Each item goes through capture, execute (store write or read
// issued, pointers updated), then load of the registered store data into
// the output register. A held result does not stop the next capture; a
// new result waits only while the output register is still full. Reset
// empties the ring and sets capacity to 4096; store contents are not
// cleared.
module byte_ring_buffer_fifo #(
	parameter int STORE_DEPTH = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  brbf_pkg::brbf_in_t         in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output brbf_pkg::brbf_out_t        out_item,
	input  logic                       cfg_we,
	input  logic [brbf_pkg::CNT_W-1:0] cfg_data
);
	import brbf_pkg::*;

	brbf_cmd_t cmd;

	// Sequencer
	brbf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Ring state and store
	brbf_datapath #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (in_item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.out_item (out_item)
	);

`ifndef SYNTH
	// Only one item in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in flight");

	// A failed operation moves nothing and returns no data
	a_fail_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_OK |->
			out_item.moved == '0 && out_item.data_out == 8'd0)
		else $error("failed operation reported bytes moved or data");

	// Refused push only when no space is left
	a_full_no_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_FULL |-> out_item.space_left == '0)
		else $error("push refused with free space left");
`endif

endmodule

[hw/rtl/brbf_datapath.sv]
// Datapath: pointers, fill count, end flag, byte store and result register.
module brbf_datapath #(
	parameter int STORE_DEPTH = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  brbf_pkg::brbf_cmd_t            cmd,
	input  brbf_pkg::brbf_in_t             in_item,
	input  logic                           cfg_we,
	input  logic [brbf_pkg::CNT_W-1:0]     cfg_data,
	output brbf_pkg::brbf_out_t            out_item
);
	import brbf_pkg::*;

	localparam int PTR_W = $clog2(STORE_DEPTH);
	localparam int SUM_W = CNT_W + 1;
	localparam logic [16:0] DEPTH_L = 17'(STORE_DEPTH);

	// Architectural state
	logic [CNT_W-1:0] cap_q;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W-1:0] wp_q;
	logic [CNT_W-1:0] held_q;
	logic             end_q;

	// Captured item and pending result
	brbf_in_t         item_q;
	logic [7:0]       rd_data_q;
	logic             has_data_q;
	logic [CNT_W-1:0] res_moved_q;
	logic [1:0]       res_status_q;
	logic [CNT_W-1:0] res_fill_q;
	logic [CNT_W-1:0] res_free_q;
	logic             res_end_q;
	brbf_out_t        out_q;

	logic [7:0] mem [STORE_DEPTH];

	logic [CNT_W-1:0] cap;
	logic [CNT_W-1:0] n_skip;
	logic [CNT_W-1:0] rd_step;
	logic [SUM_W-1:0] rd_sum;
	logic [SUM_W-1:0] rd_wrap;
	logic [SUM_W-1:0] wr_sum;
	logic [SUM_W-1:0] wr_wrap;
	logic [PTR_W-1:0] rd_addr;
	logic             mem_we;
	logic [PTR_W-1:0] rp_next;
	logic [PTR_W-1:0] wp_next;
	logic [CNT_W-1:0] held_next;
	logic             end_next;
	logic [CNT_W-1:0] moved;
	logic [1:0]       status;
	logic             has_data;

	// Effective capacity: zero acts as one, clamp to the store depth
	always_comb begin
		if (cap_q == '0) begin
			cap = CNT_W'(1);
		end else if ({4'b0, cap_q} > DEPTH_L) begin
			cap = CNT_W'(STORE_DEPTH);
		end else begin
			cap = cap_q;
		end
	end

	// Read-side pointer advance, one compare and subtract
	assign n_skip  = (item_q.amount < held_q) ? item_q.amount : held_q;
	always_comb begin
		case (item_q.operation)
			OP_PEEK: rd_step = item_q.amount;
			OP_SKIP: rd_step = n_skip;
			default: rd_step = CNT_W'(1);
		endcase
	end
	assign rd_sum  = SUM_W'(rp_q) + SUM_W'(rd_step);
	assign rd_wrap = (rd_sum >= SUM_W'(cap)) ? rd_sum - SUM_W'(cap) : rd_sum;

	// Write-side pointer advance
	assign wr_sum  = SUM_W'(wp_q) + SUM_W'(1);
	assign wr_wrap = (wr_sum >= SUM_W'(cap)) ? wr_sum - SUM_W'(cap) : wr_sum;

	// Store read address: read point for pop, offset past it for peek
	assign rd_addr = (item_q.operation == OP_POP) ? rp_q : PTR_W'(rd_wrap);

	// Per-operation next state and result
	always_comb begin
		rp_next   = rp_q;
		wp_next   = wp_q;
		held_next = held_q;
		end_next  = end_q;
		moved     = '0;
		status    = ST_OK;
		has_data  = 1'b0;
		mem_we    = 1'b0;
		case (item_q.operation)
			OP_PUSH: begin
				if (held_q >= cap) begin
					status = ST_FULL;
				end else begin
					mem_we    = 1'b1;
					wp_next   = PTR_W'(wr_wrap);
					held_next = held_q + CNT_W'(1);
					moved     = CNT_W'(1);
				end
			end
			OP_POP: begin
				if (held_q == '0) begin
					status = end_q ? ST_EMPTY_END : ST_EMPTY;
				end else begin
					has_data  = 1'b1;
					rp_next   = PTR_W'(rd_wrap);
					held_next = held_q - CNT_W'(1);
					moved     = CNT_W'(1);
				end
			end
			OP_PEEK: begin
				if (item_q.amount >= held_q) begin
					status = ST_EMPTY;
				end else begin
					has_data = 1'b1;
					moved    = CNT_W'(1);
				end
			end
			OP_SKIP: begin
				rp_next   = PTR_W'(rd_wrap);
				held_next = held_q - n_skip;
				moved     = n_skip;
			end
			OP_SET_END: begin
				end_next = 1'b1;
			end
			OP_CLEAR_END: begin
				end_next = 1'b0;
			end
			OP_RESET: begin
				rp_next   = '0;
				wp_next   = '0;
				held_next = '0;
				end_next  = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Control state: capacity, pointers, count, end flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			rp_q   <= '0;
			wp_q   <= '0;
			held_q <= '0;
			end_q  <= 1'b0;
		end else if (cfg_we) begin
			cap_q  <= cfg_data;
			rp_q   <= '0;
			wp_q   <= '0;
			held_q <= '0;
		end else if (cmd.execute) begin
			rp_q   <= rp_next;
			wp_q   <= wp_next;
			held_q <= held_next;
			end_q  <= end_next;
		end
	end

	// Byte store, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.execute && mem_we) begin
			mem[wp_q] <= item_q.data_in;
		end
		if (cmd.execute) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Item capture and pending result fields
	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			item_q <= in_item;
		end
		if (cmd.execute) begin
			has_data_q   <= has_data;
			res_moved_q  <= moved;
			res_status_q <= status;
			res_fill_q   <= held_next;
			res_free_q   <= cap - held_next;
			res_end_q    <= end_next;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_q.data_out   <= has_data_q ? rd_data_q : 8'd0;
			out_q.moved      <= res_moved_q;
			out_q.status     <= res_status_q;
			out_q.fill_level <= res_fill_q;
			out_q.space_left <= res_free_q;
			out_q.end_flag   <= res_end_q;
		end
	end

	assign out_item = out_q;

endmodule

[hw/rtl/brbf_ctrl.sv]
// Controller: sequences capture, execute and result load for one item.
module brbf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output brbf_pkg::brbf_cmd_t cmd
);
	import brbf_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	// Commands decoded from the state
	assign in_ready        = (state_q == S_IDLE);
	assign cmd.latch_item  = (state_q == S_IDLE) && in_valid;
	assign cmd.execute     = (state_q == S_EXEC);
	assign cmd.load_result = (state_q == S_RESP) && out_free;
	assign out_valid       = out_valid_q;

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces a taken one in the same cycle
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
